// File: hw/rtl/pdc_pkg.sv
package pdc_pkg;

  // Unit vectors and angles are carried in Q2.30.
  localparam int UNIT_BITS    = 30;
  localparam int CORDIC_STEPS = 30;

  localparam logic [30:0] UNIT_ONE    = 31'h4000_0000;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Datapath operations, one issued per cycle by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_DIFF,
    OP_SHR,
    OP_MAC_SQ,
    OP_MAC_DOT,
    OP_ACC,
    OP_SQRT_LEN,
    OP_LEN_SAVE,
    OP_DIV_UNIT,
    OP_UNIT_SAVE,
    OP_COS,
    OP_MUL_C,
    OP_SQRT_SINE,
    OP_TRIG_INIT,
    OP_TRIG_SPECIAL,
    OP_CORDIC,
    OP_ANGLE,
    OP_LSUM,
    OP_DIV_Q,
    OP_Q_SAVE,
    OP_ZERO,
    OP_CLEAR_RES,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       seg;
    logic [1:0] idx;
    logic [4:0] step;
    logic       capture;
    logic       load_new;
    logic       shift_in;
    logic       shift_b;
  } dp_cmd_t;

  typedef struct packed {
    logic any_big;
    logic all_zero;
    logic sqrt_done;
    logic div_done;
    logic trig_special;
  } dp_stat_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      5'd24: r = 32'd64;
      5'd25: r = 32'd32;
      5'd26: r = 32'd16;
      5'd27: r = 32'd8;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pdc_sqrt.sv
// Floor square root of a 64-bit value, two radicand bits per cycle.
module pdc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;

  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem_r, rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= 34'(rem_sh - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hw/rtl/pdc_div.sv
// Restoring 64 by 64 bit unsigned divider, one quotient bit per cycle.
module pdc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r;
  logic [63:0] den_r;
  logic [63:0] rem_r;

  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r, num_r[63]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[62:0], fits};
      rem_r <= fits ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: hw/rtl/pdc_ctrl.sv
// Sequencer for one curvature value and the output word counter.
module pdc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_point,
  input  logic               out_stall,
  input  pdc_pkg::dp_stat_t  stat,
  output pdc_pkg::dp_cmd_t   cmd,
  output logic               in_stall,
  output logic               out_valid,
  output logic               out_last_of_line
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_NORM, S_SQ, S_SQACC, S_LEN_GO, S_LEN_WAIT,
    S_UNIT_GO, S_UNIT_WAIT, S_DOT, S_DOTACC, S_COS, S_CSQ,
    S_SINE_GO, S_SINE_WAIT, S_TRIG_SEL, S_CORDIC, S_ANGLE, S_LSUM,
    S_QDIV_GO, S_QDIV_WAIT, S_ZERO, S_TWO, S_EMIT
  } state_t;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_MORE = 2'd3;

  state_t     state_r, state_nxt;
  logic       seg_r, seg_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic       last_r, last_nxt;
  logic [1:0] emit_n_r, emit_n_nxt;
  logic [1:0] out_cnt_r, out_cnt_nxt;
  logic       out_last_r, out_last_nxt;

  always_comb begin
    state_nxt    = state_r;
    seg_nxt      = seg_r;
    idx_nxt      = idx_r;
    step_nxt     = step_r;
    seen_nxt     = seen_r;
    last_nxt     = last_r;
    emit_n_nxt   = emit_n_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;

    cmd.op       = pdc_pkg::OP_NONE;
    cmd.seg      = seg_r;
    cmd.idx      = idx_r;
    cmd.step     = step_r;
    cmd.capture  = 1'b0;
    cmd.load_new = 1'b0;
    cmd.shift_in = 1'b0;
    cmd.shift_b  = 1'b0;

    if (out_cnt_r != 2'd0 && !out_stall) begin
      out_cnt_nxt = out_cnt_r - 2'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (seen_r)
            SEEN_NONE: begin
              cmd.load_new = 1'b1;
              seen_nxt = in_last_point ? SEEN_NONE : SEEN_ONE;
            end
            SEEN_ONE: begin
              if (in_last_point) begin
                cmd.capture = 1'b1;
                seen_nxt    = SEEN_NONE;
                emit_n_nxt  = 2'd2;
                last_nxt    = 1'b1;
                state_nxt   = S_TWO;
              end else begin
                cmd.shift_in = 1'b1;
                seen_nxt     = SEEN_TWO;
              end
            end
            default: begin
              cmd.capture = 1'b1;
              emit_n_nxt  = ((seen_r == SEEN_TWO) ? 2'd2 : 2'd1) + {1'b0, in_last_point};
              last_nxt    = in_last_point;
              seen_nxt    = in_last_point ? SEEN_NONE : SEEN_MORE;
              seg_nxt     = 1'b0;
              state_nxt   = S_DIFF;
            end
          endcase
        end
      end
      S_DIFF: begin
        cmd.op    = pdc_pkg::OP_DIFF;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        priority if (stat.all_zero) begin
          state_nxt = S_ZERO;
        end else if (stat.any_big) begin
          cmd.op = pdc_pkg::OP_SHR;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = pdc_pkg::OP_MAC_SQ;
        if (idx_r == 2'd2) begin
          state_nxt = S_SQACC;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_SQACC: begin
        cmd.op    = pdc_pkg::OP_ACC;
        state_nxt = S_LEN_GO;
      end
      S_LEN_GO: begin
        cmd.op    = pdc_pkg::OP_SQRT_LEN;
        state_nxt = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.op    = pdc_pkg::OP_LEN_SAVE;
          idx_nxt   = 2'd0;
          state_nxt = S_UNIT_GO;
        end
      end
      S_UNIT_GO: begin
        cmd.op    = pdc_pkg::OP_DIV_UNIT;
        state_nxt = S_UNIT_WAIT;
      end
      S_UNIT_WAIT: begin
        if (stat.div_done) begin
          cmd.op = pdc_pkg::OP_UNIT_SAVE;
          if (idx_r == 2'd2) begin
            idx_nxt = 2'd0;
            if (!seg_r) begin
              seg_nxt   = 1'b1;
              state_nxt = S_DIFF;
            end else begin
              state_nxt = S_DOT;
            end
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_UNIT_GO;
          end
        end
      end
      S_DOT: begin
        cmd.op = pdc_pkg::OP_MAC_DOT;
        if (idx_r == 2'd2) begin
          state_nxt = S_DOTACC;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_DOTACC: begin
        cmd.op    = pdc_pkg::OP_ACC;
        state_nxt = S_COS;
      end
      S_COS: begin
        cmd.op    = pdc_pkg::OP_COS;
        state_nxt = S_CSQ;
      end
      S_CSQ: begin
        cmd.op    = pdc_pkg::OP_MUL_C;
        state_nxt = S_SINE_GO;
      end
      S_SINE_GO: begin
        cmd.op    = pdc_pkg::OP_SQRT_SINE;
        state_nxt = S_SINE_WAIT;
      end
      S_SINE_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.op    = pdc_pkg::OP_TRIG_INIT;
          state_nxt = S_TRIG_SEL;
        end
      end
      S_TRIG_SEL: begin
        if (stat.trig_special) begin
          cmd.op    = pdc_pkg::OP_TRIG_SPECIAL;
          state_nxt = S_LSUM;
        end else begin
          step_nxt  = 5'd0;
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.op = pdc_pkg::OP_CORDIC;
        if (step_r == 5'(pdc_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_ANGLE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_ANGLE: begin
        cmd.op    = pdc_pkg::OP_ANGLE;
        state_nxt = S_LSUM;
      end
      S_LSUM: begin
        cmd.op    = pdc_pkg::OP_LSUM;
        state_nxt = S_QDIV_GO;
      end
      S_QDIV_GO: begin
        cmd.op    = pdc_pkg::OP_DIV_Q;
        state_nxt = S_QDIV_WAIT;
      end
      S_QDIV_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = pdc_pkg::OP_Q_SAVE;
          state_nxt = S_EMIT;
        end
      end
      S_ZERO: begin
        cmd.op    = pdc_pkg::OP_ZERO;
        state_nxt = S_EMIT;
      end
      S_TWO: begin
        cmd.op    = pdc_pkg::OP_CLEAR_RES;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Wait for the previous point's words to drain, then hand over.
        if (out_cnt_r == 2'd0) begin
          cmd.op       = pdc_pkg::OP_OUT_LOAD;
          cmd.shift_b  = 1'b1;
          out_cnt_nxt  = emit_n_r;
          out_last_nxt = last_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seg_r      <= 1'b0;
      idx_r      <= '0;
      step_r     <= '0;
      seen_r     <= SEEN_NONE;
      last_r     <= 1'b0;
      emit_n_r   <= '0;
      out_cnt_r  <= '0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seg_r      <= seg_nxt;
      idx_r      <= idx_nxt;
      step_r     <= step_nxt;
      seen_r     <= seen_nxt;
      last_r     <= last_nxt;
      emit_n_r   <= emit_n_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign in_stall         = state_r != S_IDLE;
  assign out_valid        = out_cnt_r != 2'd0;
  assign out_last_of_line = out_last_r && (out_cnt_r == 2'd1);

endmodule

// File: hw/rtl/pdc_dpath.sv
// Point store, shared multiplier, CORDIC arccosine and result registers.
module pdc_dpath #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COORD_WIDTH-1:0] in_x_coord,
  input  logic [COORD_WIDTH-1:0] in_y_coord,
  input  logic [COORD_WIDTH-1:0] in_z_coord,
  input  pdc_pkg::dp_cmd_t       cmd,
  output pdc_pkg::dp_stat_t      stat,
  output logic [31:0]            out_curvature_value,
  output logic                   out_zero_segment
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int SHW  = $clog2(DW);
  localparam int XW   = 36;
  localparam int ZW   = 34;
  localparam int E    = 2 * FRAC_BITS + 1 - pdc_pkg::UNIT_BITS;
  localparam int QSHL = (E > 0) ? E : 0;
  localparam int QSHR = (E < 0) ? -E : 0;

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(pdc_pkg::HALF_PI_Q30);

  logic [COORD_WIDTH-1:0] in_pt [3];
  logic [COORD_WIDTH-1:0] old_r [3];
  logic [COORD_WIDTH-1:0] new_r [3];
  logic [COORD_WIDTH-1:0] b_r   [3];

  logic [DW-1:0]    mag_r [3];
  logic             neg_r [3];
  logic [SHW-1:0]   s_r;
  logic [63:0]      mag64 [3];
  logic [29:0]      m30   [3];

  logic signed [31:0] unit_r [2][3];
  logic [31:0]        len_r  [2];
  logic [SHW-1:0]     sh_r   [2];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r, acc_r;

  logic [30:0]  cmag_r;
  logic         cneg_r;
  logic         special_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [31:0]  angle_r;
  logic [63:0]  lsum_r;
  logic [31:0]  res_r;
  logic         zero_r;
  logic [31:0]  out_value_r;
  logic         out_zero_r;

  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_rad;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num, div_den, div_quo;

  logic [63:0]          acc_mag, cm, qs;
  logic [31:0]          q32;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at_z, z_cl;
  logic                 any_big;

  function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                  input logic [4:0] n);
    logic [XW-1:0] m;
    m = v[XW-1] ? XW'(-v) : v;
    m = m >> n;
    return v[XW-1] ? -$signed(m) : $signed(m);
  endfunction

  assign in_pt[0] = in_x_coord;
  assign in_pt[1] = in_y_coord;
  assign in_pt[2] = in_z_coord;

  always_comb begin
    any_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag64[i] = 64'(mag_r[i]);
      m30[i]   = mag64[i][29:0];
      any_big  = any_big | (|(mag64[i] >> pdc_pkg::UNIT_BITS));
    end
  end

  // One shared 32 by 32 multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pdc_pkg::OP_MAC_SQ: begin
        mul_a = $signed({2'b00, m30[cmd.idx]});
        mul_b = $signed({2'b00, m30[cmd.idx]});
      end
      pdc_pkg::OP_MAC_DOT: begin
        mul_a = unit_r[0][cmd.idx];
        mul_b = unit_r[1][cmd.idx];
      end
      pdc_pkg::OP_MUL_C: begin
        mul_a = $signed({1'b0, cmag_r});
        mul_b = $signed({1'b0, cmag_r});
      end
      default: begin
      end
    endcase
  end

  assign acc_mag = acc_r[63] ? $unsigned(-acc_r) : $unsigned(acc_r);
  assign cm      = acc_mag >> pdc_pkg::UNIT_BITS;
  assign xs      = shr_tz(x_r, cmd.step);
  assign ys      = shr_tz(y_r, cmd.step);
  assign at_z    = $signed(ZW'(pdc_pkg::atan_q30(cmd.step)));
  assign z_cl    = z_r[ZW-1] ? '0 : ((z_r > HALF_Z) ? HALF_Z : z_r);
  assign q32     = div_quo[31:0];
  assign qs      = div_quo >> QSHR;

  assign sqrt_start = (cmd.op == pdc_pkg::OP_SQRT_LEN) || (cmd.op == pdc_pkg::OP_SQRT_SINE);
  assign sqrt_rad   = (cmd.op == pdc_pkg::OP_SQRT_LEN) ? $unsigned(acc_r)
                                                       : (64'd1 << 60) - $unsigned(prod_r);
  assign div_start  = (cmd.op == pdc_pkg::OP_DIV_UNIT) || (cmd.op == pdc_pkg::OP_DIV_Q);
  assign div_num    = (cmd.op == pdc_pkg::OP_DIV_UNIT)
                      ? (64'(m30[cmd.idx]) << pdc_pkg::UNIT_BITS)
                      : (64'(angle_r) << QSHL);
  assign div_den    = (cmd.op == pdc_pkg::OP_DIV_UNIT) ? 64'(len_r[cmd.seg]) : lsum_r;

  pdc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  pdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Point window: older, newer and the point just taken.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.capture) begin
        b_r[i] <= in_pt[i];
      end
      if (cmd.load_new) begin
        new_r[i] <= in_pt[i];
      end else if (cmd.shift_in) begin
        old_r[i] <= new_r[i];
        new_r[i] <= in_pt[i];
      end else if (cmd.shift_b) begin
        old_r[i] <= new_r[i];
        new_r[i] <= b_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pdc_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          logic [COORD_WIDTH-1:0] pa, pb;
          logic [DW-1:0]          d;
          pa = cmd.seg ? new_r[i] : old_r[i];
          pb = cmd.seg ? b_r[i] : new_r[i];
          d  = {pa[COORD_WIDTH-1], pa} - {pb[COORD_WIDTH-1], pb};
          neg_r[i] <= d[DW-1];
          mag_r[i] <= d[DW-1] ? (~d + DW'(1)) : d;
        end
        s_r <= '0;
      end
      pdc_pkg::OP_SHR: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= mag_r[i] >> 1;
        end
        s_r <= s_r + SHW'(1);
      end
      pdc_pkg::OP_MAC_SQ, pdc_pkg::OP_MAC_DOT: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= (cmd.idx == 2'd0) ? '0 : acc_r + prod_r;
      end
      pdc_pkg::OP_ACC: begin
        acc_r <= acc_r + prod_r;
      end
      pdc_pkg::OP_LEN_SAVE: begin
        len_r[cmd.seg] <= sqrt_root;
        sh_r[cmd.seg]  <= s_r;
      end
      pdc_pkg::OP_UNIT_SAVE: begin
        unit_r[cmd.seg][cmd.idx] <= neg_r[cmd.idx] ? -$signed(q32) : $signed(q32);
      end
      pdc_pkg::OP_COS: begin
        cneg_r <= acc_r[63];
        cmag_r <= (cm > 64'(pdc_pkg::UNIT_ONE)) ? pdc_pkg::UNIT_ONE : cm[30:0];
      end
      pdc_pkg::OP_MUL_C: begin
        prod_r <= mul_a * mul_b;
      end
      pdc_pkg::OP_TRIG_INIT: begin
        x_r       <= $signed(XW'(cmag_r));
        y_r       <= $signed(XW'(sqrt_root));
        z_r       <= '0;
        special_r <= (sqrt_root == 32'd0) || (cmag_r == 31'd0);
      end
      pdc_pkg::OP_TRIG_SPECIAL: begin
        if (y_r == '0) begin
          angle_r <= cneg_r ? pdc_pkg::PI_Q30 : 32'd0;
        end else begin
          angle_r <= pdc_pkg::HALF_PI_Q30;
        end
      end
      pdc_pkg::OP_CORDIC: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at_z;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at_z;
        end
      end
      pdc_pkg::OP_ANGLE: begin
        angle_r <= cneg_r ? pdc_pkg::PI_Q30 - z_cl[31:0] : z_cl[31:0];
      end
      pdc_pkg::OP_LSUM: begin
        lsum_r <= (64'(len_r[0]) << sh_r[0]) + (64'(len_r[1]) << sh_r[1]);
      end
      pdc_pkg::OP_Q_SAVE: begin
        res_r  <= (|qs[63:32]) ? '1 : qs[31:0];
        zero_r <= 1'b0;
      end
      pdc_pkg::OP_ZERO: begin
        res_r  <= '0;
        zero_r <= 1'b1;
      end
      pdc_pkg::OP_CLEAR_RES: begin
        res_r  <= '0;
        zero_r <= 1'b0;
      end
      pdc_pkg::OP_OUT_LOAD: begin
        out_value_r <= res_r;
        out_zero_r  <= zero_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.any_big      = any_big;
    stat.all_zero     = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    stat.sqrt_done    = sqrt_done;
    stat.div_done     = div_done;
    stat.trig_special = special_r;
  end

  assign out_curvature_value = out_value_r;
  assign out_zero_segment    = out_zero_r;

endmodule

// File: hw/rtl/polyline_discrete_curvature.sv
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall   | x, y, z coordinate, last_point flag
// out     | output    | out_valid/out_stall | curvature value, last_of_line, zero_segment
//
// The time an interior point takes grows when both segments need their full
// normalizing shift of three places; it is set by the shared divider (seven
// uses), the shared square root unit (three uses) and 30 CORDIC steps. The
// first point of a line is only stored, as is the second unless it ends the
// line.
// Reset is synchronous and active low; it empties the point window and drops
// any words not yet delivered. A stalled output holds its word; the next point
// is accepted and processed while earlier words still drain.
module polyline_discrete_curvature #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_x_coord,
  input  logic [COORD_WIDTH-1:0] in_y_coord,
  input  logic [COORD_WIDTH-1:0] in_z_coord,
  input  logic                   in_last_point,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_curvature_value,
  output logic                   out_last_of_line,
  output logic                   out_zero_segment
);

  // The controller walks the per-point sequence and issues one datapath
  // operation per cycle; the datapath reports unit completion and the
  // normalization flags back.
  pdc_pkg::dp_cmd_t  cmd;
  pdc_pkg::dp_stat_t stat;

  pdc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_point    (in_last_point),
    .out_stall        (out_stall),
    .stat             (stat),
    .cmd              (cmd),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_last_of_line (out_last_of_line)
  );

  // The datapath holds the last three points, turns each neighbouring segment
  // into a length and a unit vector, then forms the turning angle and divides
  // it by the mean segment length.
  pdc_dpath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_x_coord          (in_x_coord),
    .in_y_coord          (in_y_coord),
    .in_z_coord          (in_z_coord),
    .cmd                 (cmd),
    .stat                (stat),
    .out_curvature_value (out_curvature_value),
    .out_zero_segment    (out_zero_segment)
  );

endmodule
